### src/rotated_rect_corner_calc_core_macros.svh
// Assertion macros for the rotated rectangle corner calculator
`ifndef ROTATED_RECT_CORNER_CALC_CORE_MACROS_SVH
`define ROTATED_RECT_CORNER_CALC_CORE_MACROS_SVH

// check post on the cycle after pre
`define RRC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rrc: next-cycle check failed");

// check post in the same cycle as pre
`define RRC_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rrc: same-cycle check failed");

`endif

### src/rrc_pkg.sv
// Types, constants and helpers for the rotated rectangle corner calculator
`timescale 1ns / 1ps
package rrc_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int IN_BITS        = 13;
  localparam int COEF_BITS      = 17;
  localparam int PROD_BITS      = COEF_BITS + IN_BITS + 1;
  localparam int ACC_BITS       = PROD_BITS + 1;
  localparam int Q_SHIFT        = 15;
  localparam int ROT_BITS       = ACC_BITS - Q_SHIFT;
  localparam int RES_BITS       = 16;

  localparam logic [15:0] ONE_RAW       = 16'h7fff;
  localparam logic [15:0] MINUS_ONE_RAW = 16'hffff;
  localparam logic signed [COEF_BITS-1:0] ONE_FACTOR = 17'sd32768;
  localparam logic signed [COEF_BITS-1:0] MINUS_ONE_FACTOR = -17'sd32768;
  localparam logic signed [ACC_BITS-1:0]  HALF_LSB = ACC_BITS'(32'sh4000);

  typedef enum logic [0:0] {
    REG_SINE   = 1'b0,
    REG_COSINE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CORNER_TR = 2'd0,
    CORNER_BR = 2'd1,
    CORNER_BL = 2'd2
  } corner_t;

  typedef struct packed {
    logic [IN_BITS-1:0] base_h;
    logic [IN_BITS-1:0] base_v;
    logic [IN_BITS-1:0] width_px;
    logic [IN_BITS-1:0] height_px;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                 corner;
    logic signed [RES_BITS-1:0] corner_h;
    logic signed [RES_BITS-1:0] corner_v;
    logic                       last_corner;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    corner_t            corner;
    logic [IN_BITS-1:0] base_h;
    logic [IN_BITS-1:0] base_v;
    logic [IN_BITS-1:0] ph;
    logic [IN_BITS-1:0] pv;
  } job_t;

  function automatic logic signed [COEF_BITS-1:0] coef_of(logic [15:0] raw);
    logic signed [COEF_BITS-1:0] c;
    if (raw == ONE_RAW) begin
      c = ONE_FACTOR;
    end else if (raw == MINUS_ONE_RAW) begin
      c = MINUS_ONE_FACTOR;
    end else begin
      c = {raw[15], raw};
    end
    return c;
  endfunction

endpackage

### src/rrc_seq.sv
// Input holding register and three-corner job sequencer
`timescale 1ns / 1ps
module rrc_seq
  import rrc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output job_t     job,
  input  logic     job_ready
);

  localparam int USE_BITS = (COORD_BITS < IN_BITS) ? COORD_BITS : IN_BITS;
  localparam logic [IN_BITS-1:0] COORD_MASK = IN_BITS'((64'd1 << USE_BITS) - 64'd1);

  logic               busy;
  corner_t            corner;
  logic [IN_BITS-1:0] base_h;
  logic [IN_BITS-1:0] base_v;
  logic [IN_BITS-1:0] width_px;
  logic [IN_BITS-1:0] height_px;
  logic               take;
  logic               advance;

  assign in_ready = !busy || (job_ready && corner == CORNER_BL);
  assign take     = in_valid && in_ready;
  assign advance  = busy && job_ready;

  always_comb begin
    job.valid  = busy;
    job.corner = corner;
    job.base_h = base_h;
    job.base_v = base_v;
    job.ph     = (corner == CORNER_BL) ? '0 : width_px;
    job.pv     = (corner == CORNER_TR) ? '0 : height_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      corner <= CORNER_TR;
    end else if (take) begin
      busy   <= 1'b1;
      corner <= CORNER_TR;
    end else if (advance) begin
      unique case (corner)
        CORNER_TR: corner <= CORNER_BR;
        CORNER_BR: corner <= CORNER_BL;
        default: begin
          corner <= CORNER_TR;
          busy   <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      base_h    <= in_data.base_h & COORD_MASK;
      base_v    <= in_data.base_v & COORD_MASK;
      width_px  <= in_data.width_px & COORD_MASK;
      height_px <= in_data.height_px & COORD_MASK;
    end
  end

endmodule

### src/rotated_rect_corner_calc_core.sv
// Rotated rectangle corner calculator: Q15 rotation of three corners about a base point
// The sequencer issues the three corner jobs of an accepted input; a new input is taken
// only as the last corner job of the previous one moves on, so inputs never overlap.
// The result channel carries one corner per cycle while out_ready is high; multiply,
// round and base add run as three registered stages behind the corner sequencer.
// Reset: synchronous, clears all valid bits; sine resets to 0 and cosine to +1.0.
`timescale 1ns / 1ps
`include "rotated_rect_corner_calc_core_macros.svh"
module rotated_rect_corner_calc_core
  import rrc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [COEF_BITS-1:0] sin_coef;
  logic signed [COEF_BITS-1:0] cos_coef;

  job_t job;
  logic job_ready;

  logic                        v1;
  corner_t                     corner1;
  logic [IN_BITS-1:0]          base_h1;
  logic [IN_BITS-1:0]          base_v1;
  logic signed [PROD_BITS-1:0] p_ch;
  logic signed [PROD_BITS-1:0] p_sv;
  logic signed [PROD_BITS-1:0] p_sh;
  logic signed [PROD_BITS-1:0] p_cv;

  logic                        v2;
  corner_t                     corner2;
  logic [IN_BITS-1:0]          base_h2;
  logic [IN_BITS-1:0]          base_v2;
  logic signed [ROT_BITS-1:0]  rot_h;
  logic signed [ROT_BITS-1:0]  rot_v;

  logic signed [IN_BITS:0]     ph_s;
  logic signed [IN_BITS:0]     pv_s;
  logic signed [ACC_BITS-1:0]  acc_h;
  logic signed [ACC_BITS-1:0]  acc_v;
  logic [ROT_BITS:0]           sum_h;
  logic [ROT_BITS:0]           sum_v;

  logic ready1;
  logic ready2;
  logic ready3;

  rrc_seq #(
    .COORD_BITS(COORD_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job      (job),
    .job_ready(job_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_coef <= '0;
      cos_coef <= ONE_FACTOR;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SINE:   sin_coef <= coef_of(cfg_data);
        REG_COSINE: cos_coef <= coef_of(cfg_data);
        default: ;
      endcase
    end
  end

  assign ready3    = !out_valid || out_ready;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign job_ready = ready1;

  assign ph_s = signed'({1'b0, job.ph});
  assign pv_s = signed'({1'b0, job.pv});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= job.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && job.valid) begin
      corner1 <= job.corner;
      base_h1 <= job.base_h;
      base_v1 <= job.base_v;
      p_ch    <= cos_coef * ph_s;
      p_sv    <= sin_coef * pv_s;
      p_sh    <= sin_coef * ph_s;
      p_cv    <= cos_coef * pv_s;
    end
  end

  assign acc_h = ACC_BITS'(p_ch) - ACC_BITS'(p_sv) + HALF_LSB;
  assign acc_v = ACC_BITS'(p_sh) + ACC_BITS'(p_cv) + HALF_LSB;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      corner2 <= corner1;
      base_h2 <= base_h1;
      base_v2 <= base_v1;
      rot_h   <= acc_h[ACC_BITS-1:Q_SHIFT];
      rot_v   <= acc_v[ACC_BITS-1:Q_SHIFT];
    end
  end

  assign sum_h = (ROT_BITS + 1)'(base_h2) + {rot_h[ROT_BITS-1], rot_h};
  assign sum_v = (ROT_BITS + 1)'(base_v2) + {rot_v[ROT_BITS-1], rot_v};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      out_data.corner      <= corner2;
      out_data.corner_h    <= sum_h[RES_BITS-1:0];
      out_data.corner_v    <= sum_v[RES_BITS-1:0];
      out_data.last_corner <= (corner2 == CORNER_BL);
    end
  end

  `RRC_ASSERT_NEXT(a_one_item_per_three, in_valid && in_ready, !in_ready)
  `RRC_ASSERT_NEXT(a_stage1_holds, v1 && !ready2, v1 && $stable(corner1))
  `RRC_ASSERT_SAME(a_last_flag, out_valid,
    out_data.last_corner == (out_data.corner == CORNER_BL))

endmodule
